// ===== hdl/ps2m_pkg.sv =====
// Shared types, constants and helper functions of the PS/2 mouse cursor tracker.
package ps2m_pkg;

  localparam int DIM_W     = 13;
  localparam int DELTA_W   = 13;
  localparam int SUM_W     = 15;
  localparam int CURSOR_W  = 12;
  localparam int BTN_W     = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1024;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd768;
  localparam int               POS_X_RESET  = 512;
  localparam int               POS_Y_RESET  = 384;

  localparam logic [7:0] HDR_START_MASK = 8'h08;
  localparam logic [7:0] HDR_XOVF_MASK  = 8'h80;
  localparam logic [7:0] HDR_YOVF_MASK  = 8'h40;
  localparam logic [7:0] HDR_BTN_MASK   = 8'h07;

  localparam logic FUNC_RAW_BYTE = 1'b0;
  localparam logic FUNC_INJECT   = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_XBYTE  = 2'd1,
    PH_YBYTE  = 2'd2
  } phase_t;

  // One cursor update request from the decoder to the cursor stage.
  typedef struct packed {
    logic                      emit;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [BTN_W-1:0]          buttons;
  } move_t;

  // Clamp bound: zero counts as one, anything above cap saturates to cap.
  function automatic logic [DIM_W-1:0] bound_of(input logic [DIM_W-1:0] dim,
                                                 input logic [DIM_W-1:0] cap);
    logic [DIM_W-1:0] d;
    d = (dim == '0) ? DIM_W'(1) : dim;
    return (d > cap) ? cap : d;
  endfunction

  // Clamp a signed sum into 0 .. lim-1.
  function automatic logic [DIM_W-1:0] clamp_pos(input logic signed [SUM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    if (v[SUM_W-1]) begin
      r = '0;
    end else if (v[SUM_W-2:0] >= {1'b0, lim}) begin
      r = lim - DIM_W'(1);
    end else begin
      r = v[DIM_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/ps2m_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
interface ps2m_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [7:0]         byte_in;
  logic signed [12:0] delta_x;
  logic signed [12:0] delta_y;
  logic [2:0]         buttons_in;

  modport source(output valid, func, byte_in, delta_x, delta_y, buttons_in, input ready);
  modport sink(input valid, func, byte_in, delta_x, delta_y, buttons_in, output ready);
endinterface

interface ps2m_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] cursor_x;
  logic [11:0] cursor_y;
  logic [2:0]  button_bits;

  modport source(output valid, cursor_x, cursor_y, button_bits, input ready);
  modport sink(input valid, cursor_x, cursor_y, button_bits, output ready);
endinterface

// ===== hdl/ps2_mouse_packet_cursor_tracker.sv =====
// PS/2 mouse three-byte packet decoder and clamped cursor tracker, top level.
// Every input item is either a raw PS/2 mouse byte (func 0) or an injected
// relative move (func 1). Raw bytes are gathered into three-byte packets:
// a packet may only start with a byte that has bit 3 set, other bytes in
// that position are dropped, and a finished packet whose header has either
// overflow bit set is thrown away. A good packet, or any injected move,
// moves the cursor, clamps it to the screen set by the two configuration
// registers (a dimension of zero counts as one, anything above
// MAX_DIMENSION counts as MAX_DIMENSION) and gives one result item with the
// position and button bits. The header's ninth sign bits are ignored.
// An item passes an input register and then one pass of decode, add and
// clamp into the result register, so an item is taken in every cycle while
// no result is stalled; the cursor position loop closes through the
// position registers alone. A stalled result holds only the result
// register: the input register still takes one further item.
module ps2_mouse_packet_cursor_tracker #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ps2m_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ps2m_pkg::DIM_W-1:0]     cfg_wdata,
  ps2m_in_if.sink                        in_ch,
  ps2m_out_if.source                     out_ch
);
  import ps2m_pkg::*;

  // The width register cannot exceed 8191, so the bound never does either.
  localparam int CAP   = (MAX_DIMENSION < 8191) ? MAX_DIMENSION : 8191;
  // The position registers must also hold the reset position of 512.
  localparam int POS_W = (CAP > 1024) ? $clog2(CAP) : 10;

  logic                      room;
  logic                      adv;
  logic                      s_func;
  logic [7:0]                s_byte;
  logic signed [DELTA_W-1:0] s_dx;
  logic signed [DELTA_W-1:0] s_dy;
  logic [BTN_W-1:0]          s_btn;
  logic [DIM_W-1:0]          screen_width;
  logic [DIM_W-1:0]          screen_height;
  move_t                     mv;

  ps2m_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .screen_width  (screen_width),
    .screen_height (screen_height)
  );

  ps2m_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .room       (room),
    .adv        (adv),
    .func       (s_func),
    .byte_in    (s_byte),
    .delta_x    (s_dx),
    .delta_y    (s_dy),
    .buttons_in (s_btn),
    .in_ch      (in_ch)
  );

  // Decoding sees the registered item and advances only when it moves on.
  ps2m_packet u_packet (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .func       (s_func),
    .byte_in    (s_byte),
    .delta_x    (s_dx),
    .delta_y    (s_dy),
    .buttons_in (s_btn),
    .mv         (mv)
  );

  ps2m_cursor #(
    .POS_W (POS_W),
    .CAP   (CAP)
  ) u_cursor (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .mv            (mv),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .room          (room),
    .out_ch        (out_ch)
  );

  // An item that updates the cursor always leaves a result behind it.
  a_update_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && mv.emit) |=> out_ch.valid)
    else $error("cursor update produced no result item");

  // A waiting result is never dropped by an item that gives none.
  a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("pending result item lost");

  // Nothing moves on from the input register while the result is blocked.
  a_no_adv_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !adv)
    else $error("item advanced over a blocked result");

endmodule

// ===== hdl/ps2m_packet.sv =====
// Three-byte packet assembler that turns input items into cursor update requests.
module ps2m_packet (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic                              func,
  input  logic [7:0]                        byte_in,
  input  logic signed [ps2m_pkg::DELTA_W-1:0] delta_x,
  input  logic signed [ps2m_pkg::DELTA_W-1:0] delta_y,
  input  logic [ps2m_pkg::BTN_W-1:0]        buttons_in,
  output ps2m_pkg::move_t                   mv
);
  import ps2m_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] header_r, header_nxt;
  logic [7:0] xbyte_r, xbyte_nxt;

  always_comb begin
    phase_nxt  = phase_r;
    header_nxt = header_r;
    xbyte_nxt  = xbyte_r;
    if (step && func == FUNC_RAW_BYTE) begin
      case (phase_r)
        PH_HEADER: begin
          if ((byte_in & HDR_START_MASK) != '0) begin
            header_nxt = byte_in;
            phase_nxt  = PH_XBYTE;
          end
        end
        PH_XBYTE: begin
          xbyte_nxt = byte_in;
          phase_nxt = PH_YBYTE;
        end
        default: phase_nxt = PH_HEADER;
      endcase
    end
  end

  always_comb begin
    mv = '0;
    if (func == FUNC_INJECT) begin
      mv.emit    = step;
      mv.dx      = delta_x;
      mv.dy      = delta_y;
      mv.buttons = buttons_in;
    end else begin
      // The ninth sign bits in the header are ignored; Y grows downwards on screen.
      mv.emit    = step && phase_r == PH_YBYTE
                   && (header_r & (HDR_XOVF_MASK | HDR_YOVF_MASK)) == '0;
      mv.dx      = DELTA_W'($signed(xbyte_r));
      mv.dy      = -DELTA_W'($signed(byte_in));
      mv.buttons = BTN_W'(header_r & HDR_BTN_MASK);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      header_r <= '0;
      xbyte_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      header_r <= header_nxt;
      xbyte_r  <= xbyte_nxt;
    end
  end

  a_inject_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (step && func == FUNC_INJECT) |=> $stable(phase_r))
    else $error("injected motion disturbed packet assembly");

  a_raw_emit_on_third: assert property (@(posedge clk) disable iff (!rst_n)
    (step && func == FUNC_RAW_BYTE && mv.emit) |-> (phase_r == PH_YBYTE))
    else $error("packet result before the third byte");

endmodule

// ===== hdl/ps2m_cursor.sv =====
// Cursor position registers, screen clamp and result register.
module ps2m_cursor #(
  parameter int POS_W = 12,
  parameter int CAP   = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  ps2m_pkg::move_t               mv,
  input  logic [ps2m_pkg::DIM_W-1:0]    screen_width,
  input  logic [ps2m_pkg::DIM_W-1:0]    screen_height,
  output logic                          room,
  ps2m_out_if.source                    out_ch
);
  import ps2m_pkg::*;

  logic [POS_W-1:0]       pos_x_r, pos_x_nxt;
  logic [POS_W-1:0]       pos_y_r, pos_y_nxt;
  logic                   out_v_r, out_v_nxt;
  logic [BTN_W-1:0]       btn_r;
  logic [DIM_W-1:0]       lim_x, lim_y;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic                   update;

  assign room   = !out_v_r || out_ch.ready;
  assign update = adv && mv.emit;

  always_comb begin
    lim_x     = bound_of(screen_width, DIM_W'(CAP));
    lim_y     = bound_of(screen_height, DIM_W'(CAP));
    sum_x     = $signed({{(SUM_W-POS_W){1'b0}}, pos_x_r}) + SUM_W'(mv.dx);
    sum_y     = $signed({{(SUM_W-POS_W){1'b0}}, pos_y_r}) + SUM_W'(mv.dy);
    pos_x_nxt = update ? POS_W'(clamp_pos(sum_x, lim_x)) : pos_x_r;
    pos_y_nxt = update ? POS_W'(clamp_pos(sum_y, lim_y)) : pos_y_r;
    out_v_nxt = update ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= POS_W'(POS_X_RESET);
      pos_y_r <= POS_W'(POS_Y_RESET);
      out_v_r <= 1'b0;
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      btn_r <= mv.buttons;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.cursor_x    = CURSOR_W'(pos_x_r);
  assign out_ch.cursor_y    = CURSOR_W'(pos_y_r);
  assign out_ch.button_bits = btn_r;

endmodule

// ===== hdl/ps2m_in_stage.sv =====
// Input register that holds one accepted item until the cursor stage takes it.
module ps2m_in_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                room,
  output logic                                adv,
  output logic                                func,
  output logic [7:0]                          byte_in,
  output logic signed [ps2m_pkg::DELTA_W-1:0] delta_x,
  output logic signed [ps2m_pkg::DELTA_W-1:0] delta_y,
  output logic [ps2m_pkg::BTN_W-1:0]          buttons_in,
  ps2m_in_if.sink                             in_ch
);
  import ps2m_pkg::*;

  logic in_v_r, in_v_nxt;
  logic take;

  assign adv         = in_v_r && room;
  assign in_ch.ready = !in_v_r || room;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    in_v_nxt = take ? 1'b1 : (adv ? 1'b0 : in_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      func       <= in_ch.func;
      byte_in    <= in_ch.byte_in;
      delta_x    <= in_ch.delta_x;
      delta_y    <= in_ch.delta_y;
      buttons_in <= in_ch.buttons_in;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_v_r |-> in_ch.ready)
    else $error("input refused while the input register is empty");

endmodule

// ===== hdl/ps2m_mouse_packet_cursor_tracker_top_placeholder.sv =====
// Configuration registers for the screen clamp bounds.
module ps2m_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ps2m_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ps2m_pkg::DIM_W-1:0]       cfg_wdata,
  output logic [ps2m_pkg::DIM_W-1:0]       screen_width,
  output logic [ps2m_pkg::DIM_W-1:0]       screen_height
);
  import ps2m_pkg::*;

  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  width_nxt  = cfg_wdata;
        REG_SCREEN_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign screen_width  = width_r;
  assign screen_height = height_r;

endmodule
